@@ design/han_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// han_pkg: shared types, codes and tables of the HID axis normalizer
// Field widths, operation and register codes, the queue item and the
// hat-to-D-pad lookup functions.
// ----------------------------------------------------------------------------
package han_pkg;

   localparam int OP_W      = 2;
   localparam int RAW_W     = 32;
   localparam int AXIS_W    = 16;
   localparam int DPAD_W    = 4;
   localparam int CFG_W     = 32;
   localparam int FB_W      = 6;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_W     = 36;

   localparam int DEFAULT_FRAC_BITS   = 15;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [OP_W-1:0] OP_STICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
   localparam logic [OP_W-1:0] OP_HAT     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOGICAL_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGICAL_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_BITS  = 2'd2;

   localparam logic signed [CFG_W-1:0] RESET_LOGICAL_MIN = 32'sd0;
   localparam logic signed [CFG_W-1:0] RESET_LOGICAL_MAX = 32'sd65535;
   localparam logic [FB_W-1:0]         RESET_FIELD_BITS  = 6'd16;

   // Span used when the field size is zero or not below 32.
   localparam logic [RAW_W-1:0] FALLBACK_MAX = 32'h0000_FFFF;

   localparam logic [DPAD_W-1:0] DP_UP    = 4'b0001;
   localparam logic [DPAD_W-1:0] DP_RIGHT = 4'b0010;
   localparam logic [DPAD_W-1:0] DP_DOWN  = 4'b0100;
   localparam logic [DPAD_W-1:0] DP_LEFT  = 4'b1000;

   // One classified item on its way from the front end to the divider.
   typedef struct packed {
      logic               use_div;
      logic               sat_one;
      logic               neg;
      logic [RAW_W-1:0]   mag;
      logic [RAW_W-1:0]   den;
      logic [DPAD_W-1:0]  dpad;
   } han_item_type;

   function automatic logic [DPAD_W-1:0] hat8_bits(input logic [2:0] dir);
      logic [DPAD_W-1:0] bits;
      case (dir)
         3'd0: bits = DP_UP;
         3'd1: bits = DP_UP | DP_RIGHT;
         3'd2: bits = DP_RIGHT;
         3'd3: bits = DP_DOWN | DP_RIGHT;
         3'd4: bits = DP_DOWN;
         3'd5: bits = DP_DOWN | DP_LEFT;
         3'd6: bits = DP_LEFT;
         default: bits = DP_UP | DP_LEFT;
      endcase
      return bits;
   endfunction

   function automatic logic [DPAD_W-1:0] hat4_bits(input logic [1:0] dir);
      logic [DPAD_W-1:0] bits;
      case (dir)
         2'd0: bits = DP_UP;
         2'd1: bits = DP_RIGHT;
         2'd2: bits = DP_DOWN;
         default: bits = DP_LEFT;
      endcase
      return bits;
   endfunction

endpackage
`default_nettype wire

@@ design/han_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// han_if: channel interfaces of the HID axis normalizer
// Request, response and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface han_req_if import han_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [RAW_W-1:0]  raw_value;
   logic              negate;

   modport source (output valid, operation, raw_value, negate, input ready);
   modport sink (input valid, operation, raw_value, negate, output ready);
endinterface

interface han_rsp_if import han_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [AXIS_W-1:0]  axis_value;
   logic [DPAD_W-1:0]         dpad_bits;

   modport source (output valid, axis_value, dpad_bits, input ready);
   modport sink (input valid, axis_value, dpad_bits, output ready);
endinterface

interface han_csr_if import han_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CFG_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/han_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// han_front: register file and item classifier
// Holds the range registers and values derived from them, computes the
// numerator and denominator of each item, decides saturation and hat bits,
// and pushes a classified item into the queue.
// ----------------------------------------------------------------------------
module han_front import han_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   han_req_if.sink       req_chan,
   han_csr_if.sink       csr_chan,
   output logic          push,
   output han_item_type  push_item,
   input  logic          queue_full
);

   logic signed [CFG_W-1:0] lo_ff, hi_ff;
   logic [FB_W-1:0]         fb_ff;
   logic                    settle_ff;

   logic                    range_ok_ff, sext_en_ff, hat8_ff, hat4_ff;
   logic signed [CFG_W:0]   sum_ff;
   logic [RAW_W-1:0]        span_ff, m_ff, ext_mask_ff, sign_sel_ff;

   logic                    range_ok_in, sext_en_in, hat8_in, hat4_in, fb_ok;
   logic signed [CFG_W:0]   sum_in, span_full;
   logic [RAW_W-1:0]        m_in, ext_mask_in, sign_sel_in;
   logic [FB_W-1:0]         fb_less;

   logic                    csr_write, req_accept;

   logic                    f1_valid_ff;
   logic signed [NUM_W-1:0] f1_num_ff;
   logic [RAW_W-1:0]        f1_den_ff;
   logic [OP_W-1:0]         f1_op_ff;
   logic                    f1_negate_ff;
   logic [DPAD_W-1:0]       f1_dpad_ff;

   logic [RAW_W-1:0]        raw, v_bits;
   logic signed [RAW_W-1:0] raw_s;
   logic signed [RAW_W:0]   x;
   logic signed [NUM_W-1:0] shifted, k_term, num_in;
   logic [RAW_W-1:0]        den_in;
   logic                    is_stick, dbl, in_range;
   logic [2:0]              dir;
   logic [DPAD_W-1:0]       dpad_in;

   logic signed [NUM_W-1:0] den_s, den_neg, num_abs;
   logic                    st, tr, ge, le, nonpos, neg_raw;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff     <= RESET_LOGICAL_MIN;
         hi_ff     <= RESET_LOGICAL_MAX;
         fb_ff     <= RESET_FIELD_BITS;
         settle_ff <= 1'b1;
      end else begin
         settle_ff <= csr_write;
         if (csr_write) begin
            case (csr_chan.index)
               CSR_LOGICAL_MIN: lo_ff <= csr_chan.data;
               CSR_LOGICAL_MAX: hi_ff <= csr_chan.data;
               CSR_FIELD_BITS:  fb_ff <= csr_chan.data[FB_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Values that depend on the registers alone; they are registered in the cycle
   // after a write, and requests are held off until they settle.
   always_comb begin
      fb_ok       = (fb_ff != '0) && (fb_ff < FB_W'(32));
      fb_less     = fb_ff - FB_W'(1);
      range_ok_in = lo_ff < hi_ff;
      sum_in      = {lo_ff[CFG_W-1], lo_ff} + {hi_ff[CFG_W-1], hi_ff};
      span_full   = {hi_ff[CFG_W-1], hi_ff} - {lo_ff[CFG_W-1], lo_ff};
      hat8_in     = span_full == 33'sd7;
      hat4_in     = span_full == 33'sd3;
      m_in        = fb_ok ? ~({RAW_W{1'b1}} << fb_ff[4:0]) : FALLBACK_MAX;
      ext_mask_in = {RAW_W{1'b1}} << fb_ff[4:0];
      sign_sel_in = {{(RAW_W-1){1'b0}}, 1'b1} << fb_less[4:0];
      sext_en_in  = lo_ff[CFG_W-1] && fb_ok;
   end

   always_ff @(posedge clock) begin
      range_ok_ff <= range_ok_in;
      sext_en_ff  <= sext_en_in;
      hat8_ff     <= hat8_in;
      hat4_ff     <= hat4_in;
      sum_ff      <= sum_in;
      span_ff     <= span_full[RAW_W-1:0];
      m_ff        <= m_in;
      ext_mask_ff <= ext_mask_in;
      sign_sel_ff <= sign_sel_in;
   end

   assign req_chan.ready = !settle_ff && (!f1_valid_ff || !queue_full);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Numerator and denominator of the ratio, and the hat lookup.
   always_comb begin
      raw      = req_chan.raw_value;
      raw_s    = req_chan.raw_value;
      is_stick = req_chan.operation == OP_STICK;
      v_bits   = (sext_en_ff && ((raw & sign_sel_ff) != '0)) ? (raw | ext_mask_ff) : raw;
      x        = range_ok_ff ? {v_bits[RAW_W-1], v_bits} : {1'b0, raw};
      dbl      = !range_ok_ff || is_stick;
      shifted  = dbl ? {{2{x[RAW_W]}}, x, 1'b0} : {{3{x[RAW_W]}}, x};
      if (!range_ok_ff) begin
         k_term = {4'b0000, m_ff};
      end else if (is_stick) begin
         k_term = {{3{sum_ff[CFG_W]}}, sum_ff};
      end else begin
         k_term = {{4{lo_ff[CFG_W-1]}}, lo_ff};
      end
      num_in   = shifted - k_term;
      den_in   = range_ok_ff ? span_ff : m_ff;

      in_range = (raw_s >= lo_ff) && (raw_s <= hi_ff);
      dir      = raw[2:0] - lo_ff[2:0];
      dpad_in  = '0;
      if ((req_chan.operation == OP_HAT) && in_range) begin
         if (hat8_ff) begin
            dpad_in = hat8_bits(dir);
         end else if (hat4_ff) begin
            dpad_in = hat4_bits(dir[1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         f1_valid_ff <= 1'b1;
      end else if (push) begin
         f1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         f1_num_ff    <= num_in;
         f1_den_ff    <= den_in;
         f1_op_ff     <= req_chan.operation;
         f1_negate_ff <= req_chan.negate;
         f1_dpad_ff   <= dpad_in;
      end
   end

   // Saturation decisions: only ratios strictly inside the range use the
   // divider result.
   always_comb begin
      st      = f1_op_ff == OP_STICK;
      tr      = f1_op_ff == OP_TRIGGER;
      den_s   = {4'b0000, f1_den_ff};
      den_neg = -den_s;
      ge      = f1_num_ff >= den_s;
      le      = f1_num_ff <= den_neg;
      nonpos  = f1_num_ff <= 36'sd0;
      num_abs = f1_num_ff[NUM_W-1] ? -f1_num_ff : f1_num_ff;
      neg_raw = le ? 1'b1 : (ge ? 1'b0 : f1_num_ff[NUM_W-1]);

      push_item.sat_one = (st || tr) && (ge || (st && le));
      push_item.use_div = (st && !ge && !le) || (tr && !ge && !nonpos);
      push_item.neg     = st && (neg_raw ^ f1_negate_ff);
      push_item.mag     = num_abs[RAW_W-1:0];
      push_item.den     = f1_den_ff;
      push_item.dpad    = f1_dpad_ff;
   end

   assign push = f1_valid_ff && !queue_full;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      f1_valid_ff && queue_full |=> f1_valid_ff && $stable(f1_num_ff))
      else $error("front stage dropped an item while the queue was full");

   a_no_accept_settling: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_accept)
      else $error("request taken before derived range values settled");

endmodule
`default_nettype wire

@@ design/han_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// han_queue: short FIFO between classifier and divider
// Holds classified items so that either side can stall on its own.
// ----------------------------------------------------------------------------
module han_queue import han_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  han_item_type  push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output han_item_type  pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   han_item_type       entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("item pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("item popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond its depth");

endmodule
`default_nettype wire

@@ design/han_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// han_back: pipelined divider and result register
// One restoring step per stage gives floor(a * 2^F / den); a final compare
// turns it into floor(a * (2^F - 1) / den), then sign and saturation apply.
// ----------------------------------------------------------------------------
module han_back import han_pkg::*; #(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  han_item_type  item,
   output logic          pop,
   han_rsp_if.source     rsp_chan
);

   localparam int LAST  = FRAC_BITS - 1;
   localparam int RES_W = (FRAC_BITS + 1 > AXIS_W) ? FRAC_BITS + 1 : AXIS_W;
   localparam logic [FRAC_BITS-1:0] ONE_CODE = '1;

   logic                  adv;
   logic                  valid_ff [FRAC_BITS];
   han_item_type          item_ff  [FRAC_BITS];
   logic [RAW_W-1:0]      rem_ff   [FRAC_BITS];
   logic [FRAC_BITS-1:0]  q_ff     [FRAC_BITS];

   logic                  valid_src [FRAC_BITS];
   han_item_type          item_src  [FRAC_BITS];
   logic [RAW_W-1:0]      rem_src   [FRAC_BITS];
   logic [FRAC_BITS-1:0]  q_src     [FRAC_BITS];
   logic [RAW_W:0]        dbl_rem   [FRAC_BITS];
   logic                  take      [FRAC_BITS];
   logic [RAW_W:0]        diff      [FRAC_BITS];
   logic [RAW_W-1:0]      rem_in    [FRAC_BITS];
   logic [FRAC_BITS-1:0]  q_in      [FRAC_BITS];

   logic                  rsp_valid_ff;
   logic [AXIS_W-1:0]     axis_ff, axis_in;
   logic [DPAD_W-1:0]     dpad_ff;

   logic                  corr;
   logic [FRAC_BITS-1:0]  q_fix, mag_sel;
   logic [RES_W-1:0]      mag_ext, res;

   // The whole pipeline moves together whenever the result register is free.
   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign pop = adv && item_valid;

   for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
      if (s == 0) begin : g_head
         assign valid_src[s] = item_valid;
         assign item_src[s]  = item;
         assign rem_src[s]   = item.mag;
         assign q_src[s]     = '0;
      end else begin : g_body
         assign valid_src[s] = valid_ff[s-1];
         assign item_src[s]  = item_ff[s-1];
         assign rem_src[s]   = rem_ff[s-1];
         assign q_src[s]     = q_ff[s-1];
      end

      always_comb begin
         dbl_rem[s] = {rem_src[s], 1'b0};
         diff[s]    = dbl_rem[s] - {1'b0, item_src[s].den};
         take[s]    = dbl_rem[s] >= {1'b0, item_src[s].den};
         rem_in[s]  = take[s] ? diff[s][RAW_W-1:0] : dbl_rem[s][RAW_W-1:0];
         q_in[s]    = {q_src[s][FRAC_BITS-2:0], take[s]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[s] <= item_src[s];
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
         end
      end
   end

   always_comb begin
      corr    = rem_ff[LAST] < item_ff[LAST].mag;
      q_fix   = q_ff[LAST] - FRAC_BITS'(corr);
      if (item_ff[LAST].use_div) begin
         mag_sel = q_fix;
      end else if (item_ff[LAST].sat_one) begin
         mag_sel = ONE_CODE;
      end else begin
         mag_sel = '0;
      end
      mag_ext = RES_W'(mag_sel);
      res     = item_ff[LAST].neg ? -mag_ext : mag_ext;
      axis_in = res[AXIS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         axis_ff <= axis_in;
         dpad_ff <= item_ff[LAST].dpad;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.axis_value = axis_ff;
   assign rsp_chan.dpad_bits  = dpad_ff;

   a_corr_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && item_ff[LAST].use_div && corr |-> q_ff[LAST] != '0)
      else $error("quotient correction would underflow");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv && valid_ff[LAST] |=> $stable(valid_ff[LAST]) && $stable(q_ff[LAST]))
      else $error("divider advanced while the result register was blocked");

endmodule
`default_nettype wire

@@ design/hid_axis_normalizer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hid_axis_normalizer_unit: HID logical-range axis normalizer
// Maps raw HID field values to Q0.FRAC_BITS stick or trigger values, or to
// D-pad bits for hat switches, from programmable logical min/max and size.
//
//   Channel    Dir   Payload                          Handshake
//   req_chan   in    operation, raw_value, negate      valid/ready
//   rsp_chan   out   axis_value, dpad_bits             valid/ready
//   csr_chan   in    index, data                       valid/ready (always ready)
//
// One item per cycle sustained while the response side is ready; an item
// passes through the classifier register, the queue, the FRAC_BITS-stage
// restoring divider and the result register.
// Reset is synchronous; requests are held off in the cycle after reset and
// after each register write while derived range values settle.
// A stalled response freezes the divider; the queue then keeps accepting
// items until it is full.
// ----------------------------------------------------------------------------
module hid_axis_normalizer_unit import han_pkg::*; #(
   parameter int FRAC_BITS   = DEFAULT_FRAC_BITS,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   han_req_if.sink   req_chan,
   han_rsp_if.source rsp_chan,
   han_csr_if.sink   csr_chan
);

   logic          push, queue_full, pop, queue_not_empty;
   han_item_type  push_item, pop_item;

   han_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   han_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (pop_item)
   );

   han_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (pop_item),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
